// ----- hw/rtl/plotter_axis_calibrate_home_move_macros.svh -----
// assertion macros for the plotter axis sequencer
`ifndef PLOTTER_AXIS_CALIBRATE_HOME_MOVE_MACROS_SVH
`define PLOTTER_AXIS_CALIBRATE_HOME_MOVE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PACHM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PACHM_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PACHM_ASSERT(label, clk, rst_n, prop, msg)
`define PACHM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/pachm_pkg.sv -----
// shared types and constants for the plotter axis sequencer
package pachm_pkg;
	localparam int STEP_BITS = 20;
	localparam logic [STEP_BITS-1:0] STEP_MAX = {STEP_BITS{1'b1}};

	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_WAIT  = 4'd1;
	localparam logic [3:0] PH_XHI   = 4'd2;
	localparam logic [3:0] PH_XLO   = 4'd3;
	localparam logic [3:0] PH_XOFF  = 4'd4;
	localparam logic [3:0] PH_YHI   = 4'd5;
	localparam logic [3:0] PH_YLO   = 4'd6;
	localparam logic [3:0] PH_YOFF  = 4'd7;
	localparam logic [3:0] PH_HXLO  = 4'd8;
	localparam logic [3:0] PH_HXOFF = 4'd9;
	localparam logic [3:0] PH_HYLO  = 4'd10;
	localparam logic [3:0] PH_HYOFF = 4'd11;

	localparam logic [1:0] ROLE_YLO = 2'd0;
	localparam logic [1:0] ROLE_YHI = 2'd1;
	localparam logic [1:0] ROLE_XLO = 2'd2;
	localparam logic [1:0] ROLE_XHI = 2'd3;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_CAL  = 2'd1;
	localparam logic [1:0] OP_HOME = 2'd2;
	localparam logic [1:0] OP_MOVE = 2'd3;

	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_FWD_X  = 2'd2;
	localparam logic [1:0] REG_FWD_Y  = 2'd3;

	localparam int PROD_BITS = 16 + STEP_BITS;
	localparam int DIV_CNT_BITS = $clog2(PROD_BITS + 1);

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  switches;
		logic [15:0] target_x;
		logic [15:0] target_y;
	} in_item_t;

	typedef struct packed {
		logic                 step_x;
		logic                 step_y;
		logic                 dir_x;
		logic                 dir_y;
		logic                 busy_res;
		logic                 limit_hit;
		logic                 move_valid;
		logic [STEP_BITS-1:0] move_dx;
		logic [STEP_BITS-1:0] move_dy;
		logic [STEP_BITS-1:0] span_x;
		logic [STEP_BITS-1:0] span_y;
		logic [3:0]           role_levels;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic seq_load;      // run sequencer update for the held item
		logic div_start;     // begin scaling both axes
		logic move_commit;   // write move result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
	} dp_sts_t;

	function automatic logic [1:0] lowest_closed(input logic [3:0] sw);
		logic [1:0] r;
		r = 2'd0;
		if (sw[3]) r = 2'd3;
		if (sw[2]) r = 2'd2;
		if (sw[1]) r = 2'd1;
		if (sw[0]) r = 2'd0;
		return r;
	endfunction
endpackage

// ----- hw/rtl/pachm_stream_if.sv -----
// valid/ready channel interface carrying one item
interface pachm_in_if;
	logic               valid;
	logic               ready;
	pachm_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pachm_out_if;
	logic                valid;
	logic                ready;
	pachm_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/pachm_divider.sv -----
// restoring divider for floor(target*span/size) with saturation
module pachm_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [15:0]                     target,
	input  logic [pachm_pkg::STEP_BITS-1:0] span,
	input  logic [15:0]                     size,
	output logic                            done,
	output logic [pachm_pkg::STEP_BITS-1:0] quot
);
	localparam int PB = pachm_pkg::PROD_BITS;
	localparam int CB = pachm_pkg::DIV_CNT_BITS;

	logic [PB-1:0] prod_q;
	logic [PB-1:0] quo_q;
	logic [16:0]   rem_q;
	logic [15:0]   den_q;
	logic [CB-1:0] cnt_q;
	logic          run_q;
	logic          mul_q;
	logic [16:0]   rem_sh;
	logic [16:0]   rem_sub;

	assign rem_sh  = {rem_q[15:0], prod_q[PB-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			mul_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				mul_q <= 1'b1;
				run_q <= 1'b0;
			end else if (mul_q) begin
				mul_q <= 1'b0;
				run_q <= 1'b1;
				cnt_q <= CB'(PB);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CB'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= size;
			prod_q <= PB'(target) * PB'(span);
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			prod_q <= {prod_q[PB-2:0], 1'b0};
			if (!rem_sub[16]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[PB-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[PB-2:0], 1'b0};
			end
		end
	end

	assign quot = (|quo_q[PB-1:pachm_pkg::STEP_BITS]) ? pachm_pkg::STEP_MAX
		: quo_q[pachm_pkg::STEP_BITS-1:0];
endmodule

// ----- hw/rtl/pachm_datapath.sv -----
// sequencer state, calibration counters and move arithmetic
module pachm_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pachm_pkg::dp_cmd_t   cmd,
	output pachm_pkg::dp_sts_t   sts,
	input  pachm_pkg::in_item_t  item,
	input  logic [15:0]          size_x,
	input  logic [15:0]          size_y,
	input  logic                 forward_x,
	input  logic                 forward_y,
	output logic                 move_ok,
	output pachm_pkg::out_item_t res
);
	localparam int SB = pachm_pkg::STEP_BITS;

	logic [3:0]    phase_q;
	logic          half_q;
	logic [SB-1:0] travel_x_q, travel_y_q, pos_x_q, pos_y_q;
	logic [1:0]    role_q [4];
	logic          cal_q;
	logic          dir_x_q, dir_y_q;
	logic [3:0]    sw_mv_q;
	logic [SB-1:0] nx, ny;
	logic          dvx, dvy;

	logic [3:0] sw;
	logic [3:0] ph_n;
	logic       half_n, cal_n, dx_n, dy_n, stx, sty, done;
	logic [SB-1:0] tx_n, ty_n, px_n, py_n;
	logic [1:0] role_n [4];
	logic       axis, back, fwd;
	logic       lvl_xlo, lvl_xhi, lvl_ylo, lvl_yhi;

	assign sw = item.switches;
	assign move_ok = (phase_q == pachm_pkg::PH_IDLE) && (|travel_x_q) && (|travel_y_q)
		&& (|size_x) && (|size_y);

	pachm_divider u_div_x (.clk, .arst_n, .start(cmd.div_start), .target(item.target_x),
		.span(travel_x_q), .size(size_x), .done(dvx), .quot(nx));
	pachm_divider u_div_y (.clk, .arst_n, .start(cmd.div_start), .target(item.target_y),
		.span(travel_y_q), .size(size_y), .done(dvy), .quot(ny));
	assign sts.div_done = dvx & dvy;

	function automatic logic lvl(input logic [3:0] s, input logic [1:0] r);
		return s[r];
	endfunction

	always_comb begin
		ph_n = phase_q; half_n = half_q; cal_n = cal_q;
		dx_n = dir_x_q; dy_n = dir_y_q;
		tx_n = travel_x_q; ty_n = travel_y_q; px_n = pos_x_q; py_n = pos_y_q;
		for (int i = 0; i < 4; i++) role_n[i] = role_q[i];
		stx = 1'b0; sty = 1'b0; done = 1'b0;
		axis = !(phase_q == pachm_pkg::PH_XHI || phase_q == pachm_pkg::PH_XLO ||
			phase_q == pachm_pkg::PH_XOFF || phase_q == pachm_pkg::PH_HXLO ||
			phase_q == pachm_pkg::PH_HXOFF);
		back = phase_q == pachm_pkg::PH_XLO || phase_q == pachm_pkg::PH_YLO ||
			phase_q == pachm_pkg::PH_HXLO || phase_q == pachm_pkg::PH_HYLO;
		fwd = axis ? forward_y : forward_x;
		lvl_xlo = lvl(sw, role_q[pachm_pkg::ROLE_XLO]);
		lvl_ylo = lvl(sw, role_q[pachm_pkg::ROLE_YLO]);
		if (phase_q == pachm_pkg::PH_IDLE) begin
			if (item.op == pachm_pkg::OP_CAL) begin
				tx_n = '0; ty_n = '0; cal_n = 1'b0; half_n = 1'b0;
				ph_n = pachm_pkg::PH_WAIT;
			end else if (item.op == pachm_pkg::OP_HOME && cal_q) begin
				half_n = 1'b0; ph_n = pachm_pkg::PH_HXLO;
			end
		end else if (phase_q == pachm_pkg::PH_WAIT) begin
			if (sw == 4'd0) ph_n = pachm_pkg::PH_XHI;
		end else if (phase_q <= pachm_pkg::PH_HYOFF) begin
			if (!half_q) begin
				if (axis) begin
					dy_n = back ? !fwd : fwd; sty = 1'b1;
				end else begin
					dx_n = back ? !fwd : fwd; stx = 1'b1;
				end
				if (phase_q == pachm_pkg::PH_XLO && travel_x_q != pachm_pkg::STEP_MAX)
					tx_n = travel_x_q + 1'b1;
				if (phase_q == pachm_pkg::PH_YLO && travel_y_q != pachm_pkg::STEP_MAX)
					ty_n = travel_y_q + 1'b1;
				half_n = 1'b1;
			end else begin
				half_n = 1'b0;
				case (phase_q)
					pachm_pkg::PH_XHI: begin
						done = |sw;
						if (done) role_n[pachm_pkg::ROLE_XHI] = pachm_pkg::lowest_closed(sw);
					end
					pachm_pkg::PH_XLO: begin
						done = |sw;
						if (done) role_n[pachm_pkg::ROLE_XLO] = pachm_pkg::lowest_closed(sw);
					end
					pachm_pkg::PH_YHI: begin
						done = |sw;
						if (done) role_n[pachm_pkg::ROLE_YHI] = pachm_pkg::lowest_closed(sw);
					end
					pachm_pkg::PH_YLO: begin
						done = |sw;
						if (done) role_n[pachm_pkg::ROLE_YLO] = pachm_pkg::lowest_closed(sw);
					end
					pachm_pkg::PH_XOFF, pachm_pkg::PH_YOFF: done = (sw == 4'd0);
					pachm_pkg::PH_HXLO: done = lvl_xlo;
					pachm_pkg::PH_HXOFF: done = !lvl_xlo;
					pachm_pkg::PH_HYLO: done = lvl_ylo;
					default: done = !lvl_ylo;
				endcase
				if (done) begin
					if (phase_q == pachm_pkg::PH_YOFF) begin
						ph_n = pachm_pkg::PH_IDLE; cal_n = 1'b1;
					end else if (phase_q == pachm_pkg::PH_HYOFF) begin
						ph_n = pachm_pkg::PH_IDLE; px_n = '0; py_n = '0;
					end else begin
						ph_n = phase_q + 4'd1;
					end
				end
			end
		end else begin
			ph_n = pachm_pkg::PH_IDLE; half_n = 1'b0;
		end
		lvl_xhi = lvl(sw, role_n[pachm_pkg::ROLE_XHI]);
		lvl_yhi = lvl(sw, role_n[pachm_pkg::ROLE_YHI]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pachm_pkg::PH_IDLE; half_q <= 1'b0; cal_q <= 1'b0;
			travel_x_q <= '0; travel_y_q <= '0; pos_x_q <= '0; pos_y_q <= '0;
			dir_x_q <= 1'b0; dir_y_q <= 1'b0;
			for (int i = 0; i < 4; i++) role_q[i] <= 2'd0;
		end else if (cmd.seq_load) begin
			phase_q <= ph_n; half_q <= half_n; cal_q <= cal_n;
			travel_x_q <= tx_n; travel_y_q <= ty_n; pos_x_q <= px_n; pos_y_q <= py_n;
			dir_x_q <= dx_n; dir_y_q <= dy_n;
			for (int i = 0; i < 4; i++) role_q[i] <= role_n[i];
		end else if (cmd.move_commit) begin
			pos_x_q <= nx; pos_y_q <= ny;
			dir_x_q <= (nx >= pos_x_q) ? forward_x : !forward_x;
			dir_y_q <= (ny >= pos_y_q) ? forward_y : !forward_y;
		end
	end

	// switches of a move item, kept until its beat is written
	always_ff @(posedge clk) begin
		if (cmd.div_start) sw_mv_q <= sw;
	end

	// result register, written on the beat that finishes an item
	always_ff @(posedge clk) begin
		if (cmd.seq_load) begin
			res.step_x <= stx; res.step_y <= sty;
			res.dir_x <= dx_n; res.dir_y <= dy_n;
			res.busy_res <= ph_n != pachm_pkg::PH_IDLE;
			res.limit_hit <= cal_n & (((dx_n == forward_x) ? lvl_xhi :
				lvl(sw, role_n[pachm_pkg::ROLE_XLO])) | ((dy_n == forward_y) ? lvl_yhi :
				lvl(sw, role_n[pachm_pkg::ROLE_YLO])));
			res.move_valid <= 1'b0; res.move_dx <= '0; res.move_dy <= '0;
			res.span_x <= tx_n; res.span_y <= ty_n;
			res.role_levels <= cal_n ? {lvl_xhi, lvl(sw, role_n[pachm_pkg::ROLE_XLO]),
				lvl_yhi, lvl(sw, role_n[pachm_pkg::ROLE_YLO])} : 4'd0;
		end else if (cmd.move_commit) begin
			res.step_x <= 1'b0; res.step_y <= 1'b0;
			res.dir_x <= (nx >= pos_x_q) ? forward_x : !forward_x;
			res.dir_y <= (ny >= pos_y_q) ? forward_y : !forward_y;
			res.busy_res <= 1'b0;
			res.limit_hit <= cal_q & (((nx >= pos_x_q)
				? lvl(sw_mv_q, role_q[pachm_pkg::ROLE_XHI])
				: lvl(sw_mv_q, role_q[pachm_pkg::ROLE_XLO])) | ((ny >= pos_y_q)
				? lvl(sw_mv_q, role_q[pachm_pkg::ROLE_YHI])
				: lvl(sw_mv_q, role_q[pachm_pkg::ROLE_YLO])));
			res.move_valid <= 1'b1;
			res.move_dx <= (nx >= pos_x_q) ? nx - pos_x_q : pos_x_q - nx;
			res.move_dy <= (ny >= pos_y_q) ? ny - pos_y_q : pos_y_q - ny;
			res.span_x <= travel_x_q; res.span_y <= travel_y_q;
			res.role_levels <= cal_q ? {lvl(sw_mv_q, role_q[pachm_pkg::ROLE_XHI]),
				lvl(sw_mv_q, role_q[pachm_pkg::ROLE_XLO]),
				lvl(sw_mv_q, role_q[pachm_pkg::ROLE_YHI]),
				lvl(sw_mv_q, role_q[pachm_pkg::ROLE_YLO])} : 4'd0;
		end
	end
endmodule

// ----- hw/rtl/pachm_ctrl.sv -----
// controller: item handshake and move scaling sequence
`include "plotter_axis_calibrate_home_move_macros.svh"
module pachm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic               move_ok,
	output logic               out_valid,
	input  logic               out_ready,
	output pachm_pkg::dp_cmd_t cmd,
	input  pachm_pkg::dp_sts_t sts
);
	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_DIV  = 2'd1;

	logic [1:0] state_q;
	logic       full_q;
	logic       take;

	// a new item enters only when no move is being scaled and the result register is free or leaving
	assign in_ready = (state_q == C_IDLE) && (!full_q || out_ready);
	assign take = in_valid && in_ready;
	assign out_valid = full_q;

	always_comb begin
		cmd = '0;
		if (take) begin
			if (op == pachm_pkg::OP_MOVE && move_ok) cmd.div_start = 1'b1;
			else cmd.seq_load = 1'b1;
		end
		if (state_q == C_DIV && sts.div_done) cmd.move_commit = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			full_q <= 1'b0;
		end else begin
			if (cmd.seq_load || cmd.move_commit) full_q <= 1'b1;
			else if (out_valid && out_ready) full_q <= 1'b0;
			case (state_q)
				C_IDLE: if (cmd.div_start) state_q <= C_DIV;
				C_DIV: if (sts.div_done) state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	`PACHM_ASSERT(a_one_cmd, clk, arst_n, $countones(cmd) <= 1, "two commands at once")
	`PACHM_ASSERT(a_div_idle, clk, arst_n, cmd.div_start |=> state_q == C_DIV, "no scaling")
	`PACHM_ASSERT(a_no_take_busy, clk, arst_n, state_q == C_DIV |-> !in_ready, "taken in scaling")
endmodule

// ----- hw/rtl/plotter_axis_calibrate_home_move.sv -----
// top level of the two-axis plotter calibrate, home and move sequencer
// tick, calibrate and home items give their beat in the cycle after acceptance
// a move item gives its beat after the product on acceptance, a setup step,
// 36 restoring divide steps (one divider per axis), then the commit step
// one tick item a cycle unless the output stalls; no item is taken while a move is scaled
// reset: arst_n at once clears phase, spans, positions, roles, sizes; sets forward bits
`include "plotter_axis_calibrate_home_move_macros.svh"
module plotter_axis_calibrate_home_move (
	input  logic        clk,
	input  logic        arst_n,
	pachm_in_if.sink    in_ch,
	pachm_out_if.source out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [15:0] size_x_q, size_y_q;
	logic        forward_x_q, forward_y_q;
	logic        wr;
	logic        move_ok;
	pachm_pkg::dp_cmd_t cmd;
	pachm_pkg::dp_sts_t sts;

	// apb register file, word addressed
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= '0; size_y_q <= '0;
			forward_x_q <= 1'b1; forward_y_q <= 1'b1;
		end else if (wr && paddr[1:0] == 2'b00) begin
			case (paddr[3:2])
				pachm_pkg::REG_SIZE_X: size_x_q <= pwdata[15:0];
				pachm_pkg::REG_SIZE_Y: size_y_q <= pwdata[15:0];
				pachm_pkg::REG_FWD_X: forward_x_q <= pwdata[0];
				pachm_pkg::REG_FWD_Y: forward_y_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			pachm_pkg::REG_SIZE_X: prdata = {16'd0, size_x_q};
			pachm_pkg::REG_SIZE_Y: prdata = {16'd0, size_y_q};
			pachm_pkg::REG_FWD_X: prdata = {31'd0, forward_x_q};
			default: prdata = {31'd0, forward_y_q};
		endcase
	end

	// controller owns the handshake, datapath holds all sequencer state
	pachm_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .op(in_ch.data.op),
		.move_ok, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd, .sts
	);

	pachm_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .item(in_ch.data),
		.size_x(size_x_q), .size_y(size_y_q),
		.forward_x(forward_x_q), .forward_y(forward_y_q),
		.move_ok, .res(out_ch.data)
	);
endmodule

// ----- dv/pachm_checker.sv -----
// checker for the plotter axis sequencer: snoops config and channels, predicts and compares
module pachm_checker
	import pachm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	pachm_in_if         in_ch,
	pachm_out_if        out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          beats_in,
	output int          pending,
	output int          fails
);
	timeunit 1ns;
	timeprecision 1ps;

	// predicted block state
	logic [15:0]          size_x, size_y;
	logic                 fwd_x, fwd_y;
	logic [3:0]           phase;
	logic                 half;
	logic [STEP_BITS-1:0] travel_x, travel_y, pos_x, pos_y;
	logic [1:0]           role_sw [4];
	logic                 cal_done;
	logic                 dir_pin [2];

	out_item_t expected_beats[$];

	function automatic logic [1:0] first_closed(input logic [3:0] sw);
		logic [1:0] r;
		r = 2'd0;
		for (int i = 3; i >= 0; i--)
			if (sw[i]) r = i[1:0];
		return r;
	endfunction

	function automatic logic role_lvl(input logic [3:0] sw, input logic [1:0] role);
		return sw[role_sw[role]];
	endfunction

	function automatic logic [STEP_BITS-1:0] to_steps(input logic [15:0] t,
			input logic [STEP_BITS-1:0] span, input logic [15:0] sz);
		logic [63:0] q;
		q = (64'(t) * 64'(span)) / 64'(sz);
		return (q > 64'(STEP_MAX)) ? STEP_MAX : q[STEP_BITS-1:0];
	endfunction

	task automatic predict_beat(input in_item_t it, output out_item_t r);
		logic [STEP_BITS-1:0] nx, ny;
		logic axis, back, fwd, done, xa, ya;
		r = '0;
		if (phase == PH_IDLE) begin
			if (it.op == OP_CAL) begin
				travel_x = '0;
				travel_y = '0;
				cal_done = 1'b0;
				half = 1'b0;
				phase = PH_WAIT;
			end else if (it.op == OP_HOME && cal_done) begin
				half = 1'b0;
				phase = PH_HXLO;
			end else if (it.op == OP_MOVE && travel_x != 0 && travel_y != 0
					&& size_x != 0 && size_y != 0) begin
				nx = to_steps(it.target_x, travel_x, size_x);
				ny = to_steps(it.target_y, travel_y, size_y);
				if (nx >= pos_x) begin
					r.move_dx = nx - pos_x;
					dir_pin[0] = fwd_x;
				end else begin
					r.move_dx = pos_x - nx;
					dir_pin[0] = ~fwd_x;
				end
				if (ny >= pos_y) begin
					r.move_dy = ny - pos_y;
					dir_pin[1] = fwd_y;
				end else begin
					r.move_dy = pos_y - ny;
					dir_pin[1] = ~fwd_y;
				end
				pos_x = nx;
				pos_y = ny;
				r.move_valid = 1'b1;
			end
		end else if (phase == PH_WAIT) begin
			if (it.switches == 0) phase = PH_XHI;
		end else if (phase <= PH_HYOFF) begin
			axis = !(phase inside {PH_XHI, PH_XLO, PH_XOFF, PH_HXLO, PH_HXOFF});
			back = phase inside {PH_XLO, PH_YLO, PH_HXLO, PH_HYLO};
			fwd = axis ? fwd_y : fwd_x;
			if (!half) begin
				// rising half of a step pulse, travel counted on the way back
				dir_pin[axis] = back ? ~fwd : fwd;
				if (axis) r.step_y = 1'b1;
				else r.step_x = 1'b1;
				if (phase == PH_XLO && travel_x != STEP_MAX) travel_x++;
				if (phase == PH_YLO && travel_y != STEP_MAX) travel_y++;
				half = 1'b1;
			end else begin
				half = 1'b0;
				done = 1'b0;
				case (phase)
					PH_XHI: if (it.switches != 0) begin
						role_sw[ROLE_XHI] = first_closed(it.switches);
						done = 1'b1;
					end
					PH_XLO: if (it.switches != 0) begin
						role_sw[ROLE_XLO] = first_closed(it.switches);
						done = 1'b1;
					end
					PH_YHI: if (it.switches != 0) begin
						role_sw[ROLE_YHI] = first_closed(it.switches);
						done = 1'b1;
					end
					PH_YLO: if (it.switches != 0) begin
						role_sw[ROLE_YLO] = first_closed(it.switches);
						done = 1'b1;
					end
					PH_XOFF, PH_YOFF: done = (it.switches == 0);
					PH_HXLO: done = role_lvl(it.switches, ROLE_XLO);
					PH_HXOFF: done = !role_lvl(it.switches, ROLE_XLO);
					PH_HYLO: done = role_lvl(it.switches, ROLE_YLO);
					default: done = !role_lvl(it.switches, ROLE_YLO);
				endcase
				if (done) begin
					if (phase == PH_YOFF) begin
						phase = PH_IDLE;
						cal_done = 1'b1;
					end else if (phase == PH_HYOFF) begin
						phase = PH_IDLE;
						pos_x = '0;
						pos_y = '0;
					end else begin
						phase = phase + 4'd1;
					end
				end
			end
		end else begin
			phase = PH_IDLE;
			half = 1'b0;
		end
		if (cal_done) begin
			xa = (dir_pin[0] == fwd_x) ? role_lvl(it.switches, ROLE_XHI)
				: role_lvl(it.switches, ROLE_XLO);
			ya = (dir_pin[1] == fwd_y) ? role_lvl(it.switches, ROLE_YHI)
				: role_lvl(it.switches, ROLE_YLO);
			r.limit_hit = xa | ya;
			r.role_levels = {role_lvl(it.switches, ROLE_XHI), role_lvl(it.switches, ROLE_XLO),
				role_lvl(it.switches, ROLE_YHI), role_lvl(it.switches, ROLE_YLO)};
		end
		r.dir_x = dir_pin[0];
		r.dir_y = dir_pin[1];
		r.busy_res = (phase != PH_IDLE);
		r.span_x = travel_x;
		r.span_y = travel_y;
	endtask

	task automatic cmp_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t mismatch %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t r, a;
		if (!arst_n) begin
			size_x = '0;
			size_y = '0;
			fwd_x = 1'b1;
			fwd_y = 1'b1;
			phase = PH_IDLE;
			half = 1'b0;
			travel_x = '0;
			travel_y = '0;
			pos_x = '0;
			pos_y = '0;
			for (int i = 0; i < 4; i++) role_sw[i] = ROLE_YLO;
			cal_done = 1'b0;
			dir_pin[0] = 1'b0;
			dir_pin[1] = 1'b0;
			expected_beats.delete();
			beats_in <= 0;
			pending <= 0;
			fails = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_SIZE_X: size_x = pwdata[15:0];
					REG_SIZE_Y: size_y = pwdata[15:0];
					REG_FWD_X: fwd_x = pwdata[0];
					default: fwd_y = pwdata[0];
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				a = out_ch.data;
				if (expected_beats.size() == 0) begin
					$display("%0t unexpected beat %h", $realtime, a);
					fails++;
				end else begin
					r = expected_beats.pop_front();
					cmp_field("step_x", 32'(r.step_x), 32'(a.step_x));
					cmp_field("step_y", 32'(r.step_y), 32'(a.step_y));
					cmp_field("dir_x", 32'(r.dir_x), 32'(a.dir_x));
					cmp_field("dir_y", 32'(r.dir_y), 32'(a.dir_y));
					cmp_field("busy_res", 32'(r.busy_res), 32'(a.busy_res));
					cmp_field("limit_hit", 32'(r.limit_hit), 32'(a.limit_hit));
					cmp_field("move_valid", 32'(r.move_valid), 32'(a.move_valid));
					cmp_field("move_dx", 32'(r.move_dx), 32'(a.move_dx));
					cmp_field("move_dy", 32'(r.move_dy), 32'(a.move_dy));
					cmp_field("span_x", 32'(r.span_x), 32'(a.span_x));
					cmp_field("span_y", 32'(r.span_y), 32'(a.span_y));
					cmp_field("role_levels", 32'(r.role_levels), 32'(a.role_levels));
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				predict_beat(in_ch.data, r);
				expected_beats.push_back(r);
				beats_in <= beats_in + 1;
			end
			pending <= expected_beats.size();
		end
	end
endmodule

// ----- dv/tb_plotter_axis_calibrate_home_move.sv -----
// testbench top for the plotter axis sequencer: stimulus, config writes and verdict
module tb_plotter_axis_calibrate_home_move;
	import pachm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          beats_in, pending, fails;
	bit          calm;      // no back-pressure while set

	pachm_in_if  in_ch();
	pachm_out_if out_ch();

	plotter_axis_calibrate_home_move i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	pachm_checker i_checker (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.beats_in(beats_in), .pending(pending), .fails(fails)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#10ms;
		$display("FAIL");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(60, 15);
	endfunction

	// receiver back-pressure
	always @(negedge clk) begin
		int stall;
		if (!arst_n || calm) begin
			out_ch.ready <= arst_n;
			stall = 0;
		end else if (stall > 0) begin
			out_ch.ready <= 1'b0;
			stall--;
		end else begin
			out_ch.ready <= 1'b1;
			if ($urandom_range(3) == 0) stall = gap_len();
		end
	end

	task automatic send_beat(input logic [1:0] op, input logic [3:0] sw,
			input logic [15:0] tx, input logic [15:0] ty);
		int g, goal;
		in_item_t it;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid = 1'b0;
			repeat (g) @(negedge clk);
		end
		it.op = op;
		it.switches = sw;
		it.target_x = tx;
		it.target_y = ty;
		goal = beats_in + 1;
		in_ch.data = it;
		in_ch.valid = 1'b1;
		do @(negedge clk); while (beats_in != goal);
	endtask

	// let every expected beat drain before touching registers
	task automatic drain();
		in_ch.valid = 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (45) @(negedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_config(input logic [15:0] sx, input logic [15:0] sy,
			input logic fx, input logic fy);
		drain();
		reg_write(REG_SIZE_X, {16'd0, sx});
		reg_write(REG_SIZE_Y, {16'd0, sy});
		reg_write(REG_FWD_X, {31'd0, fx});
		reg_write(REG_FWD_Y, {31'd0, fy});
	endtask

	function automatic logic [15:0] pick_target();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'hffff;
			2: return 16'($urandom_range(40));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_size();
		case ($urandom_range(5))
			0: return 16'd1;
			1: return 16'hffff;
			2: return 16'd0;
			default: return 16'($urandom_range(2000, 1));
		endcase
	endfunction

	// switch pattern for a hand-written calibration: x high on switch 3,
	// x low on 1 (with 2 also closed), y high on 2, y low on 0
	logic [3:0] cal_pattern [17] = '{4'h0, 4'h0, 4'h8, 4'h0, 4'h0, 4'h0, 4'h6, 4'h0, 4'h0,
		4'h0, 4'h4, 4'h0, 4'h0, 4'h0, 4'h1, 4'h0, 4'h0};
	logic [3:0] home_pattern [8] = '{4'h0, 4'h2, 4'h0, 4'h0, 4'h0, 4'h1, 4'h0, 4'h0};

	initial begin
		int p;
		logic [1:0] op;
		logic [3:0] sw;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// not calibrated yet: home and move are both dropped
		send_beat(OP_HOME, 4'hf, 16'd0, 16'd0);
		send_beat(OP_MOVE, 4'h0, 16'hffff, 16'hffff);
		set_config(16'd100, 16'hffff, 1'b1, 1'b0);
		// calibrate, with commands arriving while busy
		send_beat(OP_CAL, 4'hf, 16'd0, 16'd0);
		send_beat(OP_MOVE, 4'hf, 16'd5, 16'd5);
		foreach (cal_pattern[i]) send_beat(OP_TICK, cal_pattern[i], 16'd0, 16'd0);
		// moves to the extremes, full-scale targets past the x size and equal to the y size
		send_beat(OP_MOVE, 4'h8, 16'hffff, 16'hffff);
		send_beat(OP_MOVE, 4'h1, 16'd0, 16'd0);
		send_beat(OP_MOVE, 4'h5, 16'd50, 16'd1);
		send_beat(OP_HOME, 4'h0, 16'd0, 16'd0);
		foreach (home_pattern[i]) send_beat(OP_TICK, home_pattern[i], 16'd0, 16'd0);
		// zero size blocks moves
		set_config(16'd0, 16'd7, 1'b0, 1'b1);
		send_beat(OP_MOVE, 4'h0, 16'd3, 16'd3);

		// random part: mostly ticks, sequences reach far because switches open often
		for (int n = 0; n < 1700; n++) begin
			if (n % 280 == 0)
				set_config(pick_size(), pick_size(), 1'($urandom), 1'($urandom));
			if (n % 280 == 140) begin
				// sender holds off until all results are back
				in_ch.valid = 1'b0;
				do @(negedge clk); while (pending != 0);
			end
			calm = (n % 400) < 60;
			p = $urandom_range(99);
			if (p < 4) op = OP_CAL;
			else if (p < 9) op = OP_HOME;
			else if (p < 24) op = OP_MOVE;
			else op = OP_TICK;
			sw = ($urandom_range(99) < 60) ? 4'h0 : 4'($urandom_range(15, 1));
			send_beat(op, sw, pick_target(), pick_target());
		end
		in_ch.valid = 1'b0;
		calm = 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (50) @(negedge clk);
		if (fails == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule

// ----- plotter_axis_calibrate_home_move.f -----
+incdir+hw/rtl
hw/rtl/pachm_pkg.sv
hw/rtl/pachm_stream_if.sv
hw/rtl/pachm_divider.sv
hw/rtl/pachm_datapath.sv
hw/rtl/pachm_ctrl.sv
hw/rtl/plotter_axis_calibrate_home_move.sv
dv/pachm_checker.sv
dv/tb_plotter_axis_calibrate_home_move.sv
